// File: rtl/idll_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// indexed doubly linked list. No dependencies.
`default_nettype none

package idll_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int ID_W        = 10;
    localparam int FN_W        = 3;
    localparam int ST_W        = 2;

    localparam logic [FN_W-1:0] FN_START     = 3'd0;
    localparam logic [FN_W-1:0] FN_INS_LEFT  = 3'd1;
    localparam logic [FN_W-1:0] FN_INS_RIGHT = 3'd2;
    localparam logic [FN_W-1:0] FN_REMOVE    = 3'd3;
    localparam logic [FN_W-1:0] FN_QUERY     = 3'd4;

    localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
    localparam logic [ST_W-1:0] ST_ABSENT = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD    = 2'd2;

    typedef struct packed {
        logic load;
        logic clear;
        logic exec;
        logic link;
        logic finish;
    } idll_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic two_step;
        logic slot_free;
    } idll_stat_t;

    function automatic logic [ADDR_W-1:0] to_addr(input logic [ID_W-1:0] id);
        logic [31:0] w;
        w = 32'(id);
        return w[ADDR_W-1:0];
    endfunction

    function automatic logic id_usable(input logic [ID_W-1:0] id);
        return (id != '0) && (32'(id) < 32'(MAX_ENTRIES));
    endfunction

endpackage

`default_nettype wire

// File: rtl/idll_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module idll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/idll_ctrl.sv
// Controller state machine: clearing sweep, accept, execute, link fix-up
// and result hand-off. Depends on idll_pkg.
`default_nettype none

module idll_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire idll_pkg::idll_stat_t stat,
    output idll_pkg::idll_cmd_t     cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_LINK,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   ready_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid && ready_reg)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = stat.two_step ? S_LINK : S_RESP;
            end
            S_LINK:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (stat.slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
        ready_next = (state_next == S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign in_ready   = ready_reg;
    assign cmd.load   = in_valid && ready_reg;
    assign cmd.clear  = (state_reg == S_CLEAR);
    assign cmd.exec   = (state_reg == S_EXEC);
    assign cmd.link   = (state_reg == S_LINK);
    assign cmd.finish = (state_reg == S_RESP) && stat.slot_free;

    a_link_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LINK |-> $past(state_reg) == S_EXEC)
        else $error("link step not preceded by execute");

    a_no_ready_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !ready_reg)
        else $error("ready raised during clearing sweep");

    a_ready_source: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg && !$past(ready_reg) |->
            ($past(state_reg) == S_RESP || $past(state_reg) == S_CLEAR))
        else $error("ready raised before result hand-off");

endmodule

`default_nettype wire

// File: rtl/idll_dpath.sv
// Datapath: link and presence tables, head/tail registers, operation decode
// and output register. Depends on idll_pkg and idll_ram.
`default_nettype none

module idll_dpath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire idll_pkg::idll_cmd_t            cmd,
    output idll_pkg::idll_stat_t                stat,
    input  wire logic [idll_pkg::FN_W-1:0]      func,
    input  wire logic [idll_pkg::ID_W-1:0]      item_id,
    input  wire logic [idll_pkg::ID_W-1:0]      anchor_id,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [idll_pkg::ST_W-1:0]      status,
    output logic      [idll_pkg::ID_W-1:0]      result_id
);

    logic [idll_pkg::FN_W-1:0]   func_reg;
    logic [idll_pkg::ID_W-1:0]   item_reg;
    logic [idll_pkg::ID_W-1:0]   anchor_reg;
    logic [idll_pkg::ID_W-1:0]   link_reg;
    logic [idll_pkg::ID_W-1:0]   head_reg;
    logic [idll_pkg::ID_W-1:0]   head_next;
    logic [idll_pkg::ID_W-1:0]   tail_reg;
    logic [idll_pkg::ID_W-1:0]   tail_next;
    logic [idll_pkg::ADDR_W-1:0] clr_cnt_reg;
    logic [idll_pkg::ST_W-1:0]   pend_st_reg;
    logic [idll_pkg::ID_W-1:0]   pend_res_reg;
    logic                        out_valid_reg;
    logic [idll_pkg::ST_W-1:0]   out_st_reg;
    logic [idll_pkg::ID_W-1:0]   out_res_reg;

    logic                        prev_we;
    logic [idll_pkg::ADDR_W-1:0] prev_waddr;
    logic [idll_pkg::ID_W-1:0]   prev_wdata;
    logic [idll_pkg::ID_W-1:0]   prev_rd;
    logic                        next_we;
    logic [idll_pkg::ADDR_W-1:0] next_waddr;
    logic [idll_pkg::ID_W-1:0]   next_wdata;
    logic [idll_pkg::ID_W-1:0]   next_rd;
    logic                        pres_we;
    logic [idll_pkg::ADDR_W-1:0] pres_waddr;
    logic                        pres_wdata;
    logic                        pres_a_rd;
    logic                        pres_i_rd;
    logic [idll_pkg::ADDR_W-1:0] link_raddr;

    logic                        anchor_present;
    logic                        item_present;
    logic                        op_ok;
    logic [idll_pkg::ST_W-1:0]   op_st;
    logic [idll_pkg::ID_W-1:0]   op_res;

    assign link_raddr = idll_pkg::to_addr((func == idll_pkg::FN_REMOVE) ? item_id : anchor_id);

    idll_ram #(.WIDTH(idll_pkg::ID_W), .DEPTH(idll_pkg::MAX_ENTRIES)) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .raddr (link_raddr),
        .rdata (prev_rd)
    );

    idll_ram #(.WIDTH(idll_pkg::ID_W), .DEPTH(idll_pkg::MAX_ENTRIES)) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (link_raddr),
        .rdata (next_rd)
    );

    idll_ram #(.WIDTH(1), .DEPTH(idll_pkg::MAX_ENTRIES)) u_pres_a_ram (
        .clk   (clk),
        .we    (pres_we),
        .waddr (pres_waddr),
        .wdata (pres_wdata),
        .raddr (idll_pkg::to_addr(anchor_id)),
        .rdata (pres_a_rd)
    );

    idll_ram #(.WIDTH(1), .DEPTH(idll_pkg::MAX_ENTRIES)) u_pres_i_ram (
        .clk   (clk),
        .we    (pres_we),
        .waddr (pres_waddr),
        .wdata (pres_wdata),
        .raddr (idll_pkg::to_addr(item_id)),
        .rdata (pres_i_rd)
    );

    assign anchor_present = idll_pkg::id_usable(anchor_reg) && pres_a_rd;
    assign item_present   = idll_pkg::id_usable(item_reg) && pres_i_rd;

    always_comb
    begin
        op_ok  = 1'b0;
        op_st  = idll_pkg::ST_BAD;
        op_res = '0;
        unique case (func_reg) inside
            idll_pkg::FN_START:
            begin
                op_ok = idll_pkg::id_usable(item_reg) && (head_reg == '0);
            end
            idll_pkg::FN_INS_LEFT, idll_pkg::FN_INS_RIGHT:
            begin
                op_ok = idll_pkg::id_usable(item_reg) && !pres_i_rd && anchor_present;
            end
            idll_pkg::FN_REMOVE:
            begin
                op_ok = item_present;
            end
            idll_pkg::FN_QUERY:
            begin
                op_ok = (anchor_reg == '0) || anchor_present;
                if (anchor_reg == '0)
                begin
                    op_res = head_reg;
                end
                else if (anchor_present)
                begin
                    op_res = next_rd;
                end
            end
            default:
            begin
                op_ok = 1'b0;
            end
        endcase
        if (op_ok)
        begin
            op_st = idll_pkg::ST_DONE;
        end
        else if (func_reg == idll_pkg::FN_REMOVE)
        begin
            op_st = idll_pkg::ST_ABSENT;
        end
    end

    always_comb
    begin
        prev_we    = 1'b0;
        prev_waddr = idll_pkg::to_addr(item_reg);
        prev_wdata = '0;
        next_we    = 1'b0;
        next_waddr = idll_pkg::to_addr(item_reg);
        next_wdata = '0;
        pres_we    = 1'b0;
        pres_waddr = idll_pkg::to_addr(item_reg);
        pres_wdata = 1'b0;
        head_next  = head_reg;
        tail_next  = tail_reg;
        if (cmd.clear)
        begin
            pres_we    = 1'b1;
            pres_waddr = clr_cnt_reg;
        end
        else if (cmd.exec && op_ok)
        begin
            case (func_reg)
                idll_pkg::FN_START:
                begin
                    prev_we    = 1'b1;
                    next_we    = 1'b1;
                    pres_we    = 1'b1;
                    pres_wdata = 1'b1;
                    head_next  = item_reg;
                    tail_next  = item_reg;
                end
                idll_pkg::FN_INS_LEFT:
                begin
                    prev_we    = 1'b1;
                    prev_wdata = prev_rd;
                    next_we    = 1'b1;
                    next_wdata = anchor_reg;
                    pres_we    = 1'b1;
                    pres_wdata = 1'b1;
                end
                idll_pkg::FN_INS_RIGHT:
                begin
                    next_we    = 1'b1;
                    next_wdata = next_rd;
                    prev_we    = 1'b1;
                    prev_wdata = anchor_reg;
                    pres_we    = 1'b1;
                    pres_wdata = 1'b1;
                end
                idll_pkg::FN_REMOVE:
                begin
                    if (prev_rd != '0)
                    begin
                        next_we    = 1'b1;
                        next_waddr = idll_pkg::to_addr(prev_rd);
                        next_wdata = next_rd;
                    end
                    else
                    begin
                        head_next = next_rd;
                    end
                    if (next_rd != '0)
                    begin
                        prev_we    = 1'b1;
                        prev_waddr = idll_pkg::to_addr(next_rd);
                        prev_wdata = prev_rd;
                    end
                    else
                    begin
                        tail_next = prev_rd;
                    end
                    pres_we = 1'b1;
                end
                default:
                begin
                    pres_we = 1'b0;
                end
            endcase
        end
        else if (cmd.link)
        begin
            case (func_reg)
                idll_pkg::FN_INS_LEFT:
                begin
                    prev_we    = 1'b1;
                    prev_waddr = idll_pkg::to_addr(anchor_reg);
                    prev_wdata = item_reg;
                    if (link_reg != '0)
                    begin
                        next_we    = 1'b1;
                        next_waddr = idll_pkg::to_addr(link_reg);
                        next_wdata = item_reg;
                    end
                    else
                    begin
                        head_next = item_reg;
                    end
                end
                idll_pkg::FN_INS_RIGHT:
                begin
                    next_we    = 1'b1;
                    next_waddr = idll_pkg::to_addr(anchor_reg);
                    next_wdata = item_reg;
                    if (link_reg != '0)
                    begin
                        prev_we    = 1'b1;
                        prev_waddr = idll_pkg::to_addr(link_reg);
                        prev_wdata = item_reg;
                    end
                    else
                    begin
                        tail_next = item_reg;
                    end
                end
                default:
                begin
                    prev_we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg   <= func;
            item_reg   <= item_id;
            anchor_reg <= anchor_id;
        end
        if (cmd.exec)
        begin
            link_reg     <= (func_reg == idll_pkg::FN_INS_LEFT) ? prev_rd : next_rd;
            pend_st_reg  <= op_st;
            pend_res_reg <= op_res;
        end
        if (cmd.finish)
        begin
            out_st_reg  <= pend_st_reg;
            out_res_reg <= pend_res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.clear_last = (clr_cnt_reg == idll_pkg::ADDR_W'(idll_pkg::MAX_ENTRIES - 1));
    assign stat.two_step   = op_ok && ((func_reg == idll_pkg::FN_INS_LEFT) ||
                                       (func_reg == idll_pkg::FN_INS_RIGHT));
    assign stat.slot_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign status    = out_st_reg;
    assign result_id = out_res_reg;

    a_head_tail_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == '0) == (tail_reg == '0))
        else $error("head and tail disagree on empty list");

    a_link_is_insert: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.link |-> (func_reg == idll_pkg::FN_INS_LEFT || func_reg == idll_pkg::FN_INS_RIGHT))
        else $error("link step for a non-insert operation");

endmodule

`default_nettype wire

// File: rtl/indexed_doubly_linked_list.sv
// Top level of the indexed doubly linked list: controller plus datapath.
// Depends on idll_pkg, idll_ctrl, idll_dpath (and idll_ram through it).
//
// After reset the presence table is swept clear, one entry per cycle, over
// all MAX_ENTRIES (1024) entries, and in_ready stays low until the sweep ends.
// Then each transfer on the input side produces exactly one result: start,
// remove, query and every refused request pass through execute and result
// hand-off; a successful insert adds a link step between them, since the second pair
// of link updates needs another pass through the single write port of the
// prev and next tables. A finished result waits in the output register while
// the next item is being processed; the block holds off only when it must
// hand over a new result and the previous one has not yet been taken.
`default_nettype none

module indexed_doubly_linked_list (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [idll_pkg::FN_W-1:0] func,
    input  wire logic [idll_pkg::ID_W-1:0] item_id,
    input  wire logic [idll_pkg::ID_W-1:0] anchor_id,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic      [idll_pkg::ST_W-1:0] status,
    output logic      [idll_pkg::ID_W-1:0] result_id
);

    idll_pkg::idll_cmd_t  cmd;
    idll_pkg::idll_stat_t stat;

    idll_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    idll_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .func      (func),
        .item_id   (item_id),
        .anchor_id (anchor_id),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .result_id (result_id)
    );

endmodule

`default_nettype wire
